// ----- sv/sorted_key_table_assert.svh -----
// Assertion macros for the sorted key table checker
`ifndef SORTED_KEY_TABLE_ASSERT_SVH
`define SORTED_KEY_TABLE_ASSERT_SVH

// Clocked assertion, disabled while reset is high
`define SKT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sorted_key_table assertion failed");

// Clocked assertion that also holds during reset
`define SKT_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("sorted_key_table assertion failed");

`endif

// ----- sv/skt_pkg.sv -----
// Shared types and codes for the sorted key table
package skt_pkg;

   localparam int KEY_FIELD_W   = 16;
   localparam int COUNT_W       = 10;
   localparam int KIND_W        = 8;
   localparam int PAYLOAD_W     = COUNT_W + KIND_W;
   localparam int INDEX_W       = 6;
   localparam int STATUS_W      = 2;
   localparam int REQ_DATA_W    = 40;
   localparam int RSP_DATA_W    = 24;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [KIND_W-1:0]   kind;
      logic [COUNT_W-1:0]  count;
      logic [INDEX_W-1:0]  index;
   } result_type;

endpackage

// ----- sv/skt_mem.sv -----
// Single-port-write, single-port-read entry memory with registered read data
module skt_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 34
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/skt_ctrl.sv -----
// Search, shift and insert sequencer with response register
module skt_ctrl import skt_pkg::*; #(
   parameter int TABLE_DEPTH = 64,
   parameter int KEY_BITS    = 16,
   parameter int AW          = $clog2(TABLE_DEPTH),
   parameter int EW          = KEY_BITS + PAYLOAD_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_action,
   input  logic [KEY_FIELD_W-1:0] req_key,
   input  logic [COUNT_W-1:0]    req_count,
   input  logic [KIND_W-1:0]     req_kind,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output result_type            rsp_result,
   output logic                  mem_wr_en,
   output logic [AW-1:0]         mem_wr_addr,
   output logic [EW-1:0]         mem_wr_data,
   output logic                  mem_rd_en,
   output logic [AW-1:0]         mem_rd_addr,
   input  logic [EW-1:0]         mem_rd_data
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int KW = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PROBE = 3'd1;
   localparam logic [2:0] S_CMP   = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_WRITE = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic                  act_ff, act_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [COUNT_W-1:0]    cnt_ff, cnt_in;
   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [CW-1:0]         lo_ff, lo_in;
   logic [CW-1:0]         hi_ff, hi_in;
   logic [CW-1:0]         mid_ff, mid_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  hit_ff, hit_in;
   logic [PAYLOAD_W-1:0]  hit_pl_ff, hit_pl_in;
   logic [AW-1:0]         src_ff, src_in;
   logic                  more_ff, more_in;
   logic                  pend_ff, pend_in;
   logic [AW-1:0]         dst_ff, dst_in;
   result_type            res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_data_ff, rsp_data_in;

   logic [CW-1:0]         mid;
   logic [KEY_BITS-1:0]   rd_key;
   logic [KEY_BITS-1:0]   req_key_m;

   assign mid       = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign rd_key    = mem_rd_data[EW-1:PAYLOAD_W];
   assign req_key_m = KEY_BITS'(req_key[KW-1:0]);
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      act_in      = act_ff;
      key_in      = key_ff;
      cnt_in      = cnt_ff;
      kind_in     = kind_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      count_in    = count_ff;
      hit_in      = hit_ff;
      hit_pl_in   = hit_pl_ff;
      src_in      = src_ff;
      more_in     = more_ff;
      pend_in     = pend_ff;
      dst_in      = dst_ff;
      res_in      = res_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = dst_ff;
      mem_wr_data = mem_rd_data;
      mem_rd_en   = 1'b0;
      mem_rd_addr = src_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in   = req_action;
               key_in   = req_key_m;
               cnt_in   = req_count;
               kind_in  = req_kind;
               lo_in    = '0;
               hi_in    = count_ff;
               hit_in   = 1'b0;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (lo_ff < hi_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = mid[AW-1:0];
               mid_in      = mid;
               state_in    = S_CMP;
            end else if (hit_ff) begin
               res_in   = '{status: (act_ff == ACT_LOOKUP) ? ST_OK : ST_DUPLICATE,
                            kind:   hit_pl_ff[KIND_W-1:0],
                            count:  hit_pl_ff[PAYLOAD_W-1:KIND_W],
                            index:  INDEX_W'(lo_ff)};
               state_in = S_DONE;
            end else if (act_ff == ACT_LOOKUP) begin
               res_in   = '{status: ST_NOT_FOUND, kind: '0, count: '0, index: '0};
               state_in = S_DONE;
            end else if (count_ff == FULL_COUNT) begin
               res_in   = '{status: ST_FULL, kind: '0, count: '0, index: '0};
               state_in = S_DONE;
            end else if (count_ff > lo_ff) begin
               src_in   = AW'(count_ff - 1'b1);
               more_in  = 1'b1;
               pend_in  = 1'b0;
               state_in = S_SHIFT;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_CMP: begin
            if (rd_key < key_ff) begin
               lo_in = mid_ff + 1'b1;
            end else begin
               hi_in = mid_ff;
            end
            if (rd_key == key_ff) begin
               hit_in    = 1'b1;
               hit_pl_in = mem_rd_data[PAYLOAD_W-1:0];
            end
            state_in = S_PROBE;
         end
         S_SHIFT: begin
            mem_wr_en   = pend_ff;
            mem_wr_addr = dst_ff;
            mem_wr_data = mem_rd_data;
            if (more_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = src_ff;
               pend_in     = 1'b1;
               dst_in      = src_ff + 1'b1;
               more_in     = (src_ff != lo_ff[AW-1:0]);
               src_in      = src_ff - 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = S_WRITE;
               end
            end
         end
         S_WRITE: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = lo_ff[AW-1:0];
            mem_wr_data = {key_ff, cnt_ff, kind_ff};
            count_in    = count_ff + 1'b1;
            res_in      = '{status: ST_OK, kind: kind_ff, count: cnt_ff,
                            index: INDEX_W'(lo_ff)};
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         more_ff      <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         more_ff      <= more_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      key_ff      <= key_in;
      cnt_ff      <= cnt_in;
      kind_ff     <= kind_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      hit_ff      <= hit_in;
      hit_pl_ff   <= hit_pl_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_data_ff;

endmodule

// ----- sv/sorted_key_table.sv -----
// Sorted key table: ordered key store with binary-search lookup and sorted insert
//
// The req channel carries one command per transaction: tuser selects insert or
// lookup, tdata carries the key and, for an insert, the payload to store.
// The rsp channel returns exactly one transaction per command: tuser holds the
// status, tdata the sorted index and the stored payload of the entry.
// Entries live in one memory with a registered read; each binary-search probe
// is a read state followed by a compare state.
// A successful insert at position p first moves the upper entries one place up,
// one entry per cycle, then writes the new one.
// One command is worked on at a time; req_tready is high while the
// sequencer is idle, including while a finished result waits in the rsp register.
// When the receiver stalls, the result holds in that register and the next
// command is still searched, finishing once the register frees up.
// Reset empties the table at once; memory contents are not cleared.
module sorted_key_table import skt_pkg::*; #(
   parameter int TABLE_DEPTH = 64,
   parameter int KEY_BITS    = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // key[15:0], operator_count[25:16],
                                             // queue_kind[33:26], zero[39:34]
   input  logic                  req_tuser,  // action
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // found_index[5:0],
                                             // found_operator_count[15:6],
                                             // found_queue_kind[23:16]
   output logic [STATUS_W-1:0]   rsp_tuser   // status
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int EW = KEY_BITS + PAYLOAD_W;

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [EW-1:0] mem_wr_data;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   logic [EW-1:0] mem_rd_data;
   result_type    result;

   skt_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BITS    (KEY_BITS),
      .AW          (AW),
      .EW          (EW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_action  (req_tuser),
      .req_key     (req_tdata[KEY_FIELD_W-1:0]),
      .req_count   (req_tdata[KEY_FIELD_W +: COUNT_W]),
      .req_kind    (req_tdata[KEY_FIELD_W+COUNT_W +: KIND_W]),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_result  (result),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   skt_mem #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (EW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_tdata = {result.kind, result.count, result.index};
   assign rsp_tuser = result.status;

endmodule

// ----- sv/skt_checker.sv -----
// Port-level checker for the sorted key table, bound to the top level
`include "sorted_key_table_assert.svh"

module skt_checker import skt_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [STATUS_W-1:0]   rsp_tuser
);

   `SKT_ASSERT_ALWAYS(a_reset_no_rsp, clock, reset |=> !rsp_tvalid)
   `SKT_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   `SKT_ASSERT(a_miss_zero, clock, reset,
      rsp_tvalid && (rsp_tuser == ST_NOT_FOUND || rsp_tuser == ST_FULL) |-> rsp_tdata == '0)
   `SKT_ASSERT(a_busy_after_accept, clock, reset, req_tvalid && req_tready |=> !req_tready)

endmodule

bind sorted_key_table skt_checker u_skt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the sorted key table: insert and lookup traffic with stalls
module testbench;
   import skt_pkg::*;

   localparam int TABLE_DEPTH = 64;
   localparam int RANDOM_CMDS = 830;
   localparam int SHOW_LIMIT  = 40;

   typedef struct {
      logic               action;
      logic [15:0]        key;
      logic [COUNT_W-1:0] count;
      logic [KIND_W-1:0]  kind;
   } table_cmd_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;

   table_cmd_type    cmd_queue[$];
   table_cmd_type    presented;
   logic [15:0]      insert_keys[$];
   result_type       table_replies[$];

   logic [15:0]          shadow_keys[TABLE_DEPTH];
   logic [PAYLOAD_W-1:0] shadow_payloads[TABLE_DEPTH];
   int                   entry_total = 0;

   int sent_total = 0, checked_total = 0, mismatch_total = 0;
   int stored_total = 0, duplicate_total = 0, full_total = 0;
   int lookup_hits = 0, lookup_misses = 0;
   int req_wait = 0, rsp_stall = 0;
   bit req_quiet = 1'b0, rsp_quiet = 1'b0;

   sorted_key_table #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .KEY_BITS   (16)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int pick_wait(input bit quiet);
      return quiet ? 0 : $urandom_range(0, 16);
   endfunction

   function automatic result_type apply_table_cmd(input table_cmd_type cmd);
      int         lo;
      int         hi;
      int         mid;
      bit         hit;
      result_type res;
      res = '0;
      lo  = 0;
      hi  = entry_total;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (shadow_keys[mid] < cmd.key) lo = mid + 1;
         else hi = mid;
      end
      hit = (lo < entry_total) && (shadow_keys[lo] == cmd.key);
      if (cmd.action == ACT_LOOKUP) begin
         if (hit) begin
            res.status = ST_OK;
            res.index = INDEX_W'(lo);
            {res.count, res.kind} = shadow_payloads[lo];
            lookup_hits++;
         end else begin
            res.status = ST_NOT_FOUND;
            lookup_misses++;
         end
      end else if (hit) begin
         res.status = ST_DUPLICATE;
         res.index = INDEX_W'(lo);
         {res.count, res.kind} = shadow_payloads[lo];
         duplicate_total++;
      end else if (entry_total >= TABLE_DEPTH) begin
         res.status = ST_FULL;
         full_total++;
      end else begin
         for (int i = entry_total; i > lo; i--) begin
            shadow_keys[i] = shadow_keys[i - 1];
            shadow_payloads[i] = shadow_payloads[i - 1];
         end
         shadow_keys[lo] = cmd.key;
         shadow_payloads[lo] = {cmd.count, cmd.kind};
         entry_total++;
         res.status = ST_OK;
         res.index = INDEX_W'(lo);
         res.count = cmd.count;
         res.kind = cmd.kind;
         stored_total++;
      end
      return res;
   endfunction

   function automatic void add_cmd(input logic action, input logic [15:0] key,
                                   input logic [COUNT_W-1:0] count,
                                   input logic [KIND_W-1:0] kind);
      table_cmd_type cmd;
      cmd.action = action;
      cmd.key = key;
      cmd.count = count;
      cmd.kind = kind;
      cmd_queue.push_back(cmd);
      if (action == ACT_INSERT) insert_keys.push_back(key);
   endfunction

   function automatic logic [15:0] pick_key();
      int unsigned r;
      logic [15:0] known;
      r = $urandom_range(0, 9);
      known = insert_keys[$urandom_range(0, insert_keys.size() - 1)];
      if (r < 5) return known;
      if (r == 5) return known + 16'd1;
      if (r == 6) return known - 16'd1;
      if (r == 7) return $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
      return 16'($urandom);
   endfunction

   task automatic report(input string field, input int unsigned want, input int unsigned got);
      mismatch_total++;
      if (mismatch_total <= SHOW_LIMIT)
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            table_replies.push_back(apply_table_cmd(presented));
            sent_total++;
            if (sent_total % 40 == 0) req_quiet = ($urandom_range(0, 2) == 0);
         end
         if (!req_tvalid || req_tready) begin
            if (req_wait > 0) begin
               req_wait--;
               req_tvalid <= 1'b0;
            end else if (cmd_queue.size() != 0) begin
               presented = cmd_queue.pop_front();
               req_tdata <= {6'b0, presented.kind, presented.count, presented.key};
               req_tuser <= presented.action;
               req_tvalid <= 1'b1;
               req_wait = pick_wait(req_quiet);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata};
            checked_total++;
            if (table_replies.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= SHOW_LIMIT)
                  $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
            end else begin
               want = table_replies.pop_front();
               if (got.status !== want.status) report("status", want.status, got.status);
               if (got.index !== want.index) report("found_index", want.index, got.index);
               if (got.count !== want.count) report("operator_count", want.count, got.count);
               if (got.kind !== want.kind) report("queue_kind", want.kind, got.kind);
            end
            if (checked_total % 40 == 0) rsp_quiet = ($urandom_range(0, 2) == 0);
            rsp_stall = pick_wait(rsp_quiet);
         end
         if (rsp_stall > 0) begin
            if (rsp_tvalid) rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int unsigned pct;
      add_cmd(ACT_LOOKUP, 16'h0000, '0, '0);
      add_cmd(ACT_LOOKUP, 16'hFFFF, '1, '1);
      add_cmd(ACT_INSERT, 16'h8000, '1, '1);
      add_cmd(ACT_INSERT, 16'h8000, 10'h155, 8'hAA);
      add_cmd(ACT_INSERT, 16'h0000, '0, '0);
      add_cmd(ACT_INSERT, 16'hFFFF, 10'h2AA, 8'h55);
      add_cmd(ACT_INSERT, 16'h7FFF, 10'h155, 8'hAA);
      add_cmd(ACT_LOOKUP, 16'h0000, '1, '1);
      add_cmd(ACT_LOOKUP, 16'hFFFF, '0, '0);
      add_cmd(ACT_LOOKUP, 16'h8000, '0, '0);
      add_cmd(ACT_LOOKUP, 16'h7FFF, '0, '0);
      add_cmd(ACT_LOOKUP, 16'h8001, '0, '0);
      add_cmd(ACT_LOOKUP, 16'h0001, '0, '0);
      add_cmd(ACT_INSERT, 16'h0000, '1, '1);
      add_cmd(ACT_INSERT, 16'hFFFF, '1, '1);
      add_cmd(ACT_INSERT, 16'h0001, 10'h001, 8'h01);
      add_cmd(ACT_INSERT, 16'hFFFE, 10'h200, 8'h80);
      add_cmd(ACT_LOOKUP, 16'h0001, '0, '0);
      add_cmd(ACT_LOOKUP, 16'hFFFE, '0, '0);
      add_cmd(ACT_LOOKUP, 16'h5555, '0, '0);
      add_cmd(ACT_LOOKUP, 16'hAAAA, '0, '0);
      for (int n = 0; n < RANDOM_CMDS; n++) begin
         pct = (n < 300) ? 50 : 30;
         add_cmd(($urandom_range(0, 99) < pct) ? ACT_INSERT : ACT_LOOKUP, pick_key(),
                 COUNT_W'($urandom), KIND_W'($urandom));
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (cmd_queue.size() != 0 || req_tvalid || table_replies.size() != 0)
         @(negedge clock);
      repeat (200) @(negedge clock);

      $display("Ran %0d commands: %0d stored, %0d duplicate, %0d refused as full",
               sent_total, stored_total, duplicate_total, full_total);
      $display("Lookups: %0d hits, %0d misses; table ended with %0d entries",
               lookup_hits, lookup_misses, entry_total);
      if (mismatch_total == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
